// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file rvx_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RVX_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RVX_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/rvx_pkg.sv -----
`timescale 1ns / 1ps
package rvx_pkg;

    localparam int MEM_BYTES     = 65536;
    localparam int NUM_REGS      = 256;
    localparam int STACK_ENTRIES = 256;

    localparam int MADDR_W  = $clog2(MEM_BYTES);
    localparam int RIDX_W   = $clog2(NUM_REGS);
    localparam int SIDX_W   = $clog2(STACK_ENTRIES);
    localparam int SDEPTH_W = SIDX_W + 1;
    localparam int PC_W     = 24;
    localparam int WORD_W   = 32;

    localparam logic [7:0] OP_NOP   = 8'h00;
    localparam logic [7:0] OP_LI    = 8'h01;
    localparam logic [7:0] OP_LUI   = 8'h02;
    localparam logic [7:0] OP_LD    = 8'h03;
    localparam logic [7:0] OP_LDP   = 8'h04;
    localparam logic [7:0] OP_ST    = 8'h05;
    localparam logic [7:0] OP_STP   = 8'h06;
    localparam logic [7:0] OP_MOV   = 8'h07;
    localparam logic [7:0] OP_ADD   = 8'h08;
    localparam logic [7:0] OP_SUB   = 8'h09;
    localparam logic [7:0] OP_MUL   = 8'h0A;
    localparam logic [7:0] OP_DIVU  = 8'h0B;
    localparam logic [7:0] OP_MODU  = 8'h0C;
    localparam logic [7:0] OP_AND   = 8'h0D;
    localparam logic [7:0] OP_OR    = 8'h0E;
    localparam logic [7:0] OP_XOR   = 8'h0F;
    localparam logic [7:0] OP_NOT   = 8'h10;
    localparam logic [7:0] OP_SHL   = 8'h11;
    localparam logic [7:0] OP_SHR   = 8'h12;
    localparam logic [7:0] OP_EQ    = 8'h13;
    localparam logic [7:0] OP_NEQ   = 8'h14;
    localparam logic [7:0] OP_LTU   = 8'h15;
    localparam logic [7:0] OP_LTS   = 8'h16;
    localparam logic [7:0] OP_LTEU  = 8'h17;
    localparam logic [7:0] OP_LTES  = 8'h18;
    localparam logic [7:0] OP_JMP   = 8'h19;
    localparam logic [7:0] OP_JZ    = 8'h1A;
    localparam logic [7:0] OP_JNZ   = 8'h1B;
    localparam logic [7:0] OP_CALL  = 8'h1C;
    localparam logic [7:0] OP_KCALL = 8'h1D;
    localparam logic [7:0] OP_RET   = 8'h1E;
    localparam logic [7:0] OP_HALT  = 8'h1F;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BADOP   = 3'd1;
    localparam logic [2:0] ST_OVF     = 3'd2;
    localparam logic [2:0] ST_UNF     = 3'd3;
    localparam logic [2:0] ST_PCRANGE = 3'd4;

    typedef enum logic [2:0] {
        K_ALU,
        K_DIV,
        K_LOAD,
        K_STORE,
        K_FLOW,
        K_BAD
    } kind_t;

    typedef struct packed {
        logic [7:0]  opcode;
        logic [7:0]  reg_a;
        logic [7:0]  reg_b;
        logic [7:0]  reg_c;
        logic [15:0] imm16;
        logic [23:0] imm24;
        kind_t       kind;
    } rvx_item_t;

    function automatic kind_t classify(input logic [7:0] op);
        kind_t k;
        case (op)
            OP_LI, OP_LUI, OP_MOV, OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_XOR,
            OP_NOT, OP_SHL, OP_SHR, OP_EQ, OP_NEQ, OP_LTU, OP_LTS, OP_LTEU,
            OP_LTES: k = K_ALU;
            OP_DIVU, OP_MODU: k = K_DIV;
            OP_LD, OP_LDP: k = K_LOAD;
            OP_ST, OP_STP: k = K_STORE;
            OP_NOP, OP_JMP, OP_JZ, OP_JNZ, OP_CALL, OP_KCALL, OP_RET,
            OP_HALT: k = K_FLOW;
            default: k = K_BAD;
        endcase
        return k;
    endfunction

endpackage

// ----- sv/rvx_in_if.sv -----
`timescale 1ns / 1ps
interface rvx_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  opcode;
    logic [7:0]  reg_a;
    logic [7:0]  reg_b;
    logic [7:0]  reg_c;
    logic [15:0] imm16;
    logic [23:0] imm24;

    modport source (output valid, opcode, reg_a, reg_b, reg_c, imm16, imm24, input ready);
    modport sink (input valid, opcode, reg_a, reg_b, reg_c, imm16, imm24, output ready);
endinterface

// ----- sv/rvx_out_if.sv -----
`timescale 1ns / 1ps
interface rvx_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] next_pc;
    logic        halted;
    logic [2:0]  status;
    logic        kcall_valid;
    logic [23:0] kcall_index;
    logic [31:0] first_arg;
    logic [31:0] second_arg;

    modport source (output valid, next_pc, halted, status, kcall_valid, kcall_index,
                    first_arg, second_arg, input ready);
    modport sink (input valid, next_pc, halted, status, kcall_valid, kcall_index,
                  first_arg, second_arg, output ready);
endinterface

// ----- sv/register_vm_instruction_execute_core.sv -----
`timescale 1ns / 1ps
// Executes one decoded instruction per input word of a 32-opcode register machine and returns
// one result word per instruction. A two-entry queue decouples the input side from the
// execution sequencer, which reads the register file in S_RD1 and S_RD2 and then carries out
// the instruction in S_EXEC. Byte loads read the data memory one byte at a time (S_MRD, then
// S_MCAP) and byte stores write one byte per S_MST step, since the data memory is one byte
// wide; division and modulo wait in S_DIV for the radix-2 divider. After reset the data memory
// is cleared one byte per cycle, all 65536 bytes, and meanwhile no instruction is executed
// (program_length writes are taken as usual).
module register_vm_instruction_execute_core (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [rvx_pkg::PC_W-1:0] cfg_wdata,
    rvx_in_if.sink                  in_ch,
    rvx_out_if.source               out_ch
);
    import rvx_pkg::*;

    logic      q_valid;
    logic      q_pop;
    rvx_item_t q_item;

    rvx_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    rvx_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_ch    (out_ch)
    );

endmodule

// ----- sv/rvx_front.sv -----
`timescale 1ns / 1ps
module rvx_front (
    input  logic              clk,
    input  logic              rst_n,
    rvx_in_if.sink            in_ch,
    output logic              q_valid,
    output rvx_pkg::rvx_item_t q_item,
    input  logic              q_pop
);
    import rvx_pkg::*;

    rvx_item_t   fifo_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  cnt_reg;
    logic        push;
    rvx_item_t   item_in;

    assign in_ch.ready = (cnt_reg != 2'd2);
    assign push        = in_ch.valid && in_ch.ready;
    assign q_valid     = (cnt_reg != 2'd0);
    assign q_item      = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        item_in.opcode = in_ch.opcode;
        item_in.reg_a  = in_ch.reg_a;
        item_in.reg_b  = in_ch.reg_b;
        item_in.reg_c  = in_ch.reg_c;
        item_in.imm16  = in_ch.imm16;
        item_in.imm24  = in_ch.imm24;
        item_in.kind   = classify(in_ch.opcode);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !q_pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (q_pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

// ----- sv/rvx_div.sv -----
`timescale 1ns / 1ps
module rvx_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [rvx_pkg::WORD_W-1:0] dividend,
    input  logic [rvx_pkg::WORD_W-1:0] divisor,
    output logic                      done,
    output logic [rvx_pkg::WORD_W-1:0] quot,
    output logic [rvx_pkg::WORD_W-1:0] rem
);
    import rvx_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [4:0]        cnt_reg;
    logic [WORD_W-1:0] q_reg;
    logic [WORD_W:0]   r_reg;
    logic [WORD_W-1:0] d_reg;
    logic [WORD_W:0]   r_sh;
    logic [WORD_W:0]   diff;

    assign r_sh = {r_reg[WORD_W-1:0], q_reg[WORD_W-1]};
    assign diff = r_sh - {1'b0, d_reg};
    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg[WORD_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
            q_reg    <= '0;
            r_reg    <= '0;
            d_reg    <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
            q_reg    <= dividend;
            r_reg    <= '0;
            d_reg    <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[WORD_W])
            begin
                r_reg <= diff;
                q_reg <= {q_reg[WORD_W-2:0], 1'b1};
            end
            else
            begin
                r_reg <= r_sh;
                q_reg <= {q_reg[WORD_W-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

endmodule

// ----- sv/rvx_back.sv -----
`timescale 1ns / 1ps
module rvx_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [rvx_pkg::PC_W-1:0] cfg_wdata,
    input  logic                    q_valid,
    input  rvx_pkg::rvx_item_t      q_item,
    output logic                    q_pop,
    rvx_out_if.source               out_ch
);
    import rvx_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD1,
        S_RD2,
        S_EXEC,
        S_DIV,
        S_MRD,
        S_MCAP,
        S_MST,
        S_FIN
    } state_t;

    localparam logic [MADDR_W-1:0]  MEM_LAST  = MADDR_W'(MEM_BYTES - 1);
    localparam logic [SDEPTH_W-1:0] STACK_TOP = SDEPTH_W'(STACK_ENTRIES);

    state_t              state_reg;
    rvx_item_t           item_reg;
    logic [PC_W-1:0]     pc_reg;
    logic                halt_reg;
    logic [SDEPTH_W-1:0] depth_reg;
    logic [PC_W-1:0]     plen_reg;
    logic [WORD_W-1:0]   vb_reg;
    logic [WORD_W-1:0]   vc_reg;
    logic [WORD_W-1:0]   res_reg;
    logic                wr_reg;
    logic [2:0]          st_reg;
    logic [PC_W-1:0]     npc_reg;
    logic                kc_reg;
    logic                hset_reg;
    logic [MADDR_W-1:0]  maddr_reg;
    logic [2:0]          bidx_reg;
    logic [2:0]          blen_reg;
    logic [WORD_W-1:0]   sval_reg;
    logic                clr_reg;
    logic [MADDR_W-1:0]  clr_addr_reg;
    logic [WORD_W-1:0]   r0_reg;
    logic [WORD_W-1:0]   r1_reg;

    logic                out_valid_reg;
    logic [PC_W-1:0]     out_pc_reg;
    logic                out_halted_reg;
    logic [2:0]          out_status_reg;
    logic                out_kc_reg;
    logic [PC_W-1:0]     out_kidx_reg;
    logic [WORD_W-1:0]   out_arg0_reg;
    logic [WORD_W-1:0]   out_arg1_reg;

    logic [WORD_W-1:0]   rf_mem [NUM_REGS];
    logic [NUM_REGS-1:0] rf_vld_reg;
    logic [RIDX_W-1:0]   rf_raddr0;
    logic [RIDX_W-1:0]   rf_raddr1;
    logic [RIDX_W-1:0]   rf_waddr;
    logic                rf_we;
    logic [WORD_W-1:0]   rf_q0_reg;
    logic [WORD_W-1:0]   rf_q1_reg;
    logic                rf_v0_reg;
    logic                rf_v1_reg;
    logic [WORD_W-1:0]   rdv0;
    logic [WORD_W-1:0]   rdv1;

    logic [7:0]          dm_mem [MEM_BYTES];
    logic                dm_we;
    logic [MADDR_W-1:0]  dm_waddr;
    logic [7:0]          dm_wdata;
    logic [MADDR_W-1:0]  dm_raddr;
    logic [7:0]          dm_q_reg;

    logic [PC_W-1:0]     stk_mem [STACK_ENTRIES];
    logic                stk_we;
    logic [PC_W-1:0]     stk_q_reg;

    logic                div_start;
    logic                div_done;
    logic [WORD_W-1:0]   div_quot;
    logic [WORD_W-1:0]   div_rem;

    logic [PC_W-1:0]     npc_seq;
    logic [PC_W-1:0]     br_target;
    logic [PC_W-1:0]     exec_npc;
    logic [2:0]          n_lim;
    logic [WORD_W-1:0]   keep;
    logic [WORD_W-1:0]   alu_res;
    logic [2:0]          bidx_inc;

    function automatic logic [WORD_W-1:0] alu(input logic [7:0] op,
                                               input logic [WORD_W-1:0] va,
                                               input logic [WORD_W-1:0] vb,
                                               input logic [WORD_W-1:0] vc,
                                               input logic [15:0] imm);
        logic [WORD_W-1:0] r;
        logic              big;
        big = |vc[WORD_W-1:5];
        case (op)
            OP_LI:   r = {va[31:16], imm};
            OP_LUI:  r = {imm, va[15:0]};
            OP_MOV:  r = vb;
            OP_ADD:  r = vb + vc;
            OP_SUB:  r = vb - vc;
            OP_MUL:  r = vb * vc;
            OP_AND:  r = vb & vc;
            OP_OR:   r = vb | vc;
            OP_XOR:  r = vb ^ vc;
            OP_NOT:  r = ~vb;
            OP_SHL:  r = big ? '0 : (vb << vc[4:0]);
            OP_SHR:  r = big ? '0 : (vb >> vc[4:0]);
            OP_EQ:   r = {31'd0, vb == vc};
            OP_NEQ:  r = {31'd0, vb != vc};
            OP_LTU:  r = {31'd0, vb < vc};
            OP_LTS:  r = {31'd0, $signed(vb) < $signed(vc)};
            OP_LTEU: r = {31'd0, vb <= vc};
            OP_LTES: r = {31'd0, $signed(vb) <= $signed(vc)};
            default: r = '0;
        endcase
        return r;
    endfunction

    assign rdv0      = rf_v0_reg ? rf_q0_reg : '0;
    assign rdv1      = rf_v1_reg ? rf_q1_reg : '0;
    assign npc_seq   = pc_reg + PC_W'(1);
    assign br_target = npc_seq + {{(PC_W - 16){item_reg.imm16[15]}}, item_reg.imm16};
    assign n_lim     = (item_reg.reg_c > 8'd4) ? 3'd4 : item_reg.reg_c[2:0];
    assign alu_res   = alu(item_reg.opcode, rdv0, vb_reg, vc_reg, item_reg.imm16);
    assign bidx_inc  = bidx_reg + 3'd1;

    always_comb
    begin
        case (n_lim)
            3'd0:    keep = 32'hFFFFFFFF;
            3'd1:    keep = 32'hFFFFFF00;
            3'd2:    keep = 32'hFFFF0000;
            3'd3:    keep = 32'hFF000000;
            default: keep = 32'h00000000;
        endcase
    end

    always_comb
    begin
        exec_npc = npc_seq;
        if (item_reg.kind == K_BAD)
        begin
            exec_npc = pc_reg;
        end
        else if (item_reg.kind == K_FLOW)
        begin
            case (item_reg.opcode)
                OP_JMP:
                begin
                    exec_npc = br_target;
                end
                OP_JZ:
                begin
                    if (rdv0 == '0)
                    begin
                        exec_npc = br_target;
                    end
                end
                OP_JNZ:
                begin
                    if (rdv0 != '0)
                    begin
                        exec_npc = br_target;
                    end
                end
                OP_CALL:
                begin
                    exec_npc = (depth_reg == STACK_TOP) ? pc_reg : item_reg.imm24;
                end
                OP_RET:
                begin
                    exec_npc = (depth_reg == '0) ? pc_reg : stk_q_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign q_pop = (state_reg == S_IDLE) && q_valid && !clr_reg
                   && (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        if (state_reg == S_RD1)
        begin
            rf_raddr0 = item_reg.reg_b[RIDX_W-1:0];
        end
        else
        begin
            rf_raddr0 = item_reg.reg_a[RIDX_W-1:0];
        end
        rf_raddr1 = item_reg.reg_c[RIDX_W-1:0];
        rf_waddr  = item_reg.reg_a[RIDX_W-1:0];
        rf_we     = (state_reg == S_FIN) && wr_reg;
    end

    always_comb
    begin
        dm_raddr = maddr_reg + MADDR_W'(bidx_reg);
        if (clr_reg)
        begin
            dm_we    = 1'b1;
            dm_waddr = clr_addr_reg;
            dm_wdata = 8'd0;
        end
        else
        begin
            dm_we    = (state_reg == S_MST);
            dm_waddr = dm_raddr;
            dm_wdata = 8'(sval_reg >> {bidx_reg, 3'b000});
        end
    end

    assign stk_we = (state_reg == S_EXEC) && (item_reg.kind == K_FLOW)
                    && (item_reg.opcode == OP_CALL) && (depth_reg != STACK_TOP);
    assign div_start = (state_reg == S_EXEC) && (item_reg.kind == K_DIV);

    always_ff @(posedge clk)
    begin
        if (rf_we)
        begin
            rf_mem[rf_waddr] <= res_reg;
        end
        rf_q0_reg <= rf_mem[rf_raddr0];
        rf_q1_reg <= rf_mem[rf_raddr1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_vld_reg <= '0;
            rf_v0_reg  <= 1'b0;
            rf_v1_reg  <= 1'b0;
        end
        else
        begin
            if (rf_we)
            begin
                rf_vld_reg[rf_waddr] <= 1'b1;
            end
            rf_v0_reg <= rf_vld_reg[rf_raddr0];
            rf_v1_reg <= rf_vld_reg[rf_raddr1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dm_we)
        begin
            dm_mem[dm_waddr] <= dm_wdata;
        end
        dm_q_reg <= dm_mem[dm_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[depth_reg[SIDX_W-1:0]] <= npc_seq;
        end
        stk_q_reg <= stk_mem[SIDX_W'(depth_reg - SDEPTH_W'(1))];
    end

    rvx_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (vb_reg),
        .divisor  (vc_reg),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            item_reg       <= '0;
            pc_reg         <= '0;
            halt_reg       <= 1'b0;
            depth_reg      <= '0;
            plen_reg       <= '0;
            vb_reg         <= '0;
            vc_reg         <= '0;
            res_reg        <= '0;
            wr_reg         <= 1'b0;
            st_reg         <= ST_OK;
            npc_reg        <= '0;
            kc_reg         <= 1'b0;
            hset_reg       <= 1'b0;
            maddr_reg      <= '0;
            bidx_reg       <= '0;
            blen_reg       <= '0;
            sval_reg       <= '0;
            clr_reg        <= 1'b1;
            clr_addr_reg   <= '0;
            r0_reg         <= '0;
            r1_reg         <= '0;
            out_valid_reg  <= 1'b0;
            out_pc_reg     <= '0;
            out_halted_reg <= 1'b0;
            out_status_reg <= ST_OK;
            out_kc_reg     <= 1'b0;
            out_kidx_reg   <= '0;
            out_arg0_reg   <= '0;
            out_arg1_reg   <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                plen_reg <= cfg_wdata;
            end
            if (clr_reg)
            begin
                clr_addr_reg <= clr_addr_reg + MADDR_W'(1);
                if (clr_addr_reg == MEM_LAST)
                begin
                    clr_reg <= 1'b0;
                end
            end
            if (rf_we && (rf_waddr == RIDX_W'(0)))
            begin
                r0_reg <= res_reg;
            end
            if (rf_we && (rf_waddr == RIDX_W'(1)))
            begin
                r1_reg <= res_reg;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (q_pop)
                    begin
                        item_reg <= q_item;
                        kc_reg   <= 1'b0;
                        wr_reg   <= 1'b0;
                        hset_reg <= 1'b0;
                        npc_reg  <= pc_reg;
                        if (halt_reg)
                        begin
                            st_reg    <= ST_OK;
                            state_reg <= S_FIN;
                        end
                        else if (pc_reg >= plen_reg)
                        begin
                            st_reg    <= ST_PCRANGE;
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            st_reg    <= ST_OK;
                            state_reg <= S_RD1;
                        end
                    end
                end
                S_RD1:
                begin
                    state_reg <= S_RD2;
                end
                S_RD2:
                begin
                    vb_reg    <= rdv0;
                    vc_reg    <= rdv1;
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    npc_reg  <= exec_npc;
                    bidx_reg <= 3'd0;
                    sval_reg <= rdv0;
                    case (item_reg.kind)
                        K_ALU:
                        begin
                            res_reg   <= alu_res;
                            wr_reg    <= 1'b1;
                            state_reg <= S_FIN;
                        end
                        K_DIV:
                        begin
                            state_reg <= S_DIV;
                        end
                        K_LOAD:
                        begin
                            if (item_reg.opcode == OP_LD)
                            begin
                                maddr_reg <= MADDR_W'(item_reg.imm16);
                                res_reg   <= '0;
                                blen_reg  <= 3'd4;
                                state_reg <= S_MRD;
                            end
                            else
                            begin
                                maddr_reg <= MADDR_W'(vb_reg);
                                res_reg   <= rdv0 & keep;
                                blen_reg  <= n_lim;
                                if (n_lim == 3'd0)
                                begin
                                    wr_reg    <= 1'b1;
                                    state_reg <= S_FIN;
                                end
                                else
                                begin
                                    state_reg <= S_MRD;
                                end
                            end
                        end
                        K_STORE:
                        begin
                            if (item_reg.opcode == OP_ST)
                            begin
                                maddr_reg <= MADDR_W'(item_reg.imm16);
                                blen_reg  <= 3'd4;
                                state_reg <= S_MST;
                            end
                            else
                            begin
                                maddr_reg <= MADDR_W'(vb_reg);
                                blen_reg  <= n_lim;
                                state_reg <= (n_lim == 3'd0) ? S_FIN : S_MST;
                            end
                        end
                        K_FLOW:
                        begin
                            case (item_reg.opcode)
                                OP_CALL:
                                begin
                                    if (depth_reg == STACK_TOP)
                                    begin
                                        st_reg <= ST_OVF;
                                    end
                                    else
                                    begin
                                        depth_reg <= depth_reg + SDEPTH_W'(1);
                                    end
                                end
                                OP_RET:
                                begin
                                    if (depth_reg == '0)
                                    begin
                                        st_reg <= ST_UNF;
                                    end
                                    else
                                    begin
                                        depth_reg <= depth_reg - SDEPTH_W'(1);
                                    end
                                end
                                OP_KCALL:
                                begin
                                    kc_reg <= 1'b1;
                                end
                                OP_HALT:
                                begin
                                    hset_reg <= 1'b1;
                                end
                                default:
                                begin
                                end
                            endcase
                            state_reg <= S_FIN;
                        end
                        default:
                        begin
                            st_reg    <= ST_BADOP;
                            state_reg <= S_FIN;
                        end
                    endcase
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        res_reg   <= (item_reg.opcode == OP_DIVU) ? div_quot : div_rem;
                        wr_reg    <= 1'b1;
                        state_reg <= S_FIN;
                    end
                end
                S_MRD:
                begin
                    state_reg <= S_MCAP;
                end
                S_MCAP:
                begin
                    res_reg  <= res_reg | (WORD_W'(dm_q_reg) << {bidx_reg, 3'b000});
                    bidx_reg <= bidx_inc;
                    if (bidx_inc == blen_reg)
                    begin
                        wr_reg    <= 1'b1;
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        state_reg <= S_MRD;
                    end
                end
                S_MST:
                begin
                    bidx_reg <= bidx_inc;
                    if (bidx_inc == blen_reg)
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    pc_reg         <= npc_reg;
                    halt_reg       <= halt_reg || hset_reg || (st_reg != ST_OK);
                    out_valid_reg  <= 1'b1;
                    out_pc_reg     <= npc_reg;
                    out_halted_reg <= halt_reg || hset_reg || (st_reg != ST_OK);
                    out_status_reg <= st_reg;
                    out_kc_reg     <= kc_reg;
                    out_kidx_reg   <= kc_reg ? item_reg.imm24 : '0;
                    out_arg0_reg   <= kc_reg ? r0_reg : '0;
                    out_arg1_reg   <= kc_reg ? r1_reg : '0;
                    state_reg      <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.next_pc     = out_pc_reg;
    assign out_ch.halted      = out_halted_reg;
    assign out_ch.status      = out_status_reg;
    assign out_ch.kcall_valid = out_kc_reg;
    assign out_ch.kcall_index = out_kidx_reg;
    assign out_ch.first_arg   = out_arg0_reg;
    assign out_ch.second_arg  = out_arg1_reg;

endmodule

// ----- sv/rvx_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rvx_checker (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic [rvx_pkg::PC_W-1:0] next_pc,
    input logic                    halted,
    input logic [2:0]              status,
    input logic                    kcall_valid
);
    import rvx_pkg::*;

    logic            seen_halt_reg;
    logic [PC_W-1:0] last_pc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_halt_reg <= 1'b0;
            last_pc_reg   <= '0;
        end
        else if (out_valid && out_ready && halted && !seen_halt_reg)
        begin
            seen_halt_reg <= 1'b1;
            last_pc_reg   <= next_pc;
        end
    end

    `RVX_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(next_pc) && $stable(status), "stalled result word changed")
    `RVX_ASSERT_IMP(a_stay_halted, out_valid && seen_halt_reg, halted && (status == ST_OK) && !kcall_valid, "machine left the halted state")
    `RVX_ASSERT_IMP(a_pc_frozen, out_valid && seen_halt_reg, next_pc == last_pc_reg, "PC moved after halt")
    `RVX_ASSERT_IMP(a_error_halts, out_valid && (status != ST_OK), halted && !kcall_valid, "error without halt")

endmodule

bind register_vm_instruction_execute_core rvx_checker u_rvx_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .next_pc     (out_ch.next_pc),
    .halted      (out_ch.halted),
    .status      (out_ch.status),
    .kcall_valid (out_ch.kcall_valid)
);

// ----- tb/register_vm_instruction_execute_checker.sv -----
`timescale 1ns / 1ps
module register_vm_instruction_execute_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [23:0] cfg_wdata,
    rvx_in_if           in_ch,
    rvx_out_if          out_ch,
    output int          errors,
    output int          outstanding
);
    import rvx_pkg::*;

    typedef struct packed {
        logic [23:0] pc;
        logic        halted;
        logic [2:0]  status;
        logic        kcall_valid;
        logic [23:0] kcall_index;
        logic [31:0] first_arg;
        logic [31:0] second_arg;
    } vm_result_t;

    logic [31:0] regs [0:NUM_REGS-1];
    logic [7:0]  mem [0:MEM_BYTES-1];
    logic [23:0] ret_stack [0:STACK_ENTRIES-1];
    int          depth;
    logic [23:0] vm_pc;
    logic        vm_halted;
    logic [23:0] vm_plen;
    vm_result_t  expected_q [$];

    function automatic logic [31:0] mem_read(input logic [15:0] addr, input int n);
        logic [31:0] v;
        logic [15:0] p;
        v = '0;
        for (int i = 0; i < n; i++)
        begin
            p = addr + 16'(i);
            v = v | (32'(mem[p]) << (8 * i));
        end
        return v;
    endfunction

    function automatic void mem_write(input logic [15:0] addr, input logic [31:0] v,
                                      input int n);
        logic [15:0] p;
        for (int i = 0; i < n; i++)
        begin
            p = addr + 16'(i);
            mem[p] = v[8*i +: 8];
        end
    endfunction

    function automatic logic [23:0] branch_target(input logic [23:0] npc,
                                                  input logic [15:0] off);
        return npc + {{8{off[15]}}, off};
    endfunction

    function automatic vm_result_t execute_instr(input logic [7:0] op, input logic [7:0] a,
                                                 input logic [7:0] b, input logic [7:0] c,
                                                 input logic [15:0] i16,
                                                 input logic [23:0] i24);
        logic [31:0] vb;
        logic [31:0] vc;
        logic [31:0] keep;
        logic [23:0] npc;
        logic [2:0]  st;
        logic        kc;
        int          cnt;
        vm_result_t  r;
        st = ST_OK;
        kc = 1'b0;
        cnt = (c > 4) ? 4 : int'(c);
        if (!vm_halted)
        begin
            if (vm_pc >= vm_plen)
            begin
                st = ST_PCRANGE;
                vm_halted = 1'b1;
            end
            else
            begin
                npc = vm_pc + 24'd1;
                vb = regs[b];
                vc = regs[c];
                case (op)
                    OP_NOP: ;
                    OP_LI: regs[a] = {regs[a][31:16], i16};
                    OP_LUI: regs[a] = {i16, regs[a][15:0]};
                    OP_LD: regs[a] = mem_read(i16, 4);
                    OP_LDP:
                    begin
                        keep = (cnt == 4) ? 32'd0 : (32'hFFFF_FFFF << (8 * cnt));
                        regs[a] = (regs[a] & keep) | mem_read(vb[15:0], cnt);
                    end
                    OP_ST: mem_write(i16, regs[a], 4);
                    OP_STP: mem_write(vb[15:0], regs[a], cnt);
                    OP_MOV: regs[a] = vb;
                    OP_ADD: regs[a] = vb + vc;
                    OP_SUB: regs[a] = vb - vc;
                    OP_MUL: regs[a] = vb * vc;
                    OP_DIVU: regs[a] = (vc == 0) ? 32'hFFFF_FFFF : vb / vc;
                    OP_MODU: regs[a] = (vc == 0) ? vb : vb % vc;
                    OP_AND: regs[a] = vb & vc;
                    OP_OR: regs[a] = vb | vc;
                    OP_XOR: regs[a] = vb ^ vc;
                    OP_NOT: regs[a] = ~vb;
                    OP_SHL: regs[a] = (vc >= 32) ? 32'd0 : (vb << vc[4:0]);
                    OP_SHR: regs[a] = (vc >= 32) ? 32'd0 : (vb >> vc[4:0]);
                    OP_EQ: regs[a] = 32'(vb == vc);
                    OP_NEQ: regs[a] = 32'(vb != vc);
                    OP_LTU: regs[a] = 32'(vb < vc);
                    OP_LTS: regs[a] = 32'($signed(vb) < $signed(vc));
                    OP_LTEU: regs[a] = 32'(vb <= vc);
                    OP_LTES: regs[a] = 32'($signed(vb) <= $signed(vc));
                    OP_JMP: npc = branch_target(npc, i16);
                    OP_JZ: if (regs[a] == 0) npc = branch_target(npc, i16);
                    OP_JNZ: if (regs[a] != 0) npc = branch_target(npc, i16);
                    OP_CALL:
                    begin
                        if (depth >= STACK_ENTRIES)
                        begin
                            st = ST_OVF;
                        end
                        else
                        begin
                            ret_stack[depth] = npc;
                            depth++;
                            npc = i24;
                        end
                    end
                    OP_KCALL: kc = 1'b1;
                    OP_RET:
                    begin
                        if (depth == 0)
                        begin
                            st = ST_UNF;
                        end
                        else
                        begin
                            depth--;
                            npc = ret_stack[depth];
                        end
                    end
                    OP_HALT: vm_halted = 1'b1;
                    default: st = ST_BADOP;
                endcase
                if (st != ST_OK)
                    vm_halted = 1'b1;
                else
                    vm_pc = npc;
            end
        end
        r.pc = vm_pc;
        r.halted = vm_halted;
        r.status = st;
        r.kcall_valid = kc;
        r.kcall_index = kc ? i24 : 24'd0;
        r.first_arg = kc ? regs[0] : 32'd0;
        r.second_arg = kc ? regs[1] : 32'd0;
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] exp_v,
                                          input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        vm_result_t e;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
                regs[i] = '0;
            for (int i = 0; i < MEM_BYTES; i++)
                mem[i] = '0;
            depth = 0;
            vm_pc = '0;
            vm_halted = 1'b0;
            vm_plen = '0;
            expected_q.delete();
            errors = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
                vm_plen = cfg_wdata;
            if (in_ch.valid && in_ch.ready)
                expected_q.push_back(execute_instr(in_ch.opcode, in_ch.reg_a, in_ch.reg_b,
                                                   in_ch.reg_c, in_ch.imm16, in_ch.imm24));
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result word, expected none, actual pc %0h",
                             $time, out_ch.next_pc);
                end
                else
                begin
                    e = expected_q.pop_front();
                    compare_field("next_pc", e.pc, out_ch.next_pc);
                    compare_field("halted", e.halted, out_ch.halted);
                    compare_field("status", e.status, out_ch.status);
                    compare_field("kcall_valid", e.kcall_valid, out_ch.kcall_valid);
                    compare_field("kcall_index", e.kcall_index, out_ch.kcall_index);
                    compare_field("first_arg", e.first_arg, out_ch.first_arg);
                    compare_field("second_arg", e.second_arg, out_ch.second_arg);
                end
            end
            outstanding = expected_q.size();
        end
    end
endmodule

// ----- tb/register_vm_instruction_execute_core_tb.sv -----
`timescale 1ns / 1ps
module register_vm_instruction_execute_core_tb;
    import rvx_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [23:0] cfg_wdata;
    int          errors;
    int          outstanding;
    int          snd_idle;
    int          rcv_idle;
    int          call_depth;
    logic        stall;
    event        begin_stall;

    rvx_in_if  in_ch ();
    rvx_out_if out_ch ();

    register_vm_instruction_execute_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    register_vm_instruction_execute_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
        out_ch.ready <= !stall && ($urandom_range(99) >= rcv_idle);

    initial
    begin
        stall = 1'b0;
        forever
        begin
            @(begin_stall);
            stall = 1'b1;
            repeat (400) @(posedge clk);
            stall = 1'b0;
        end
    end

    initial
    begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic send_instr(input logic [7:0] op, input logic [7:0] a, input logic [7:0] b,
                              input logic [7:0] c, input logic [15:0] i16,
                              input logic [23:0] i24);
        while ($urandom_range(99) < snd_idle)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.opcode <= op;
        in_ch.reg_a <= a;
        in_ch.reg_b <= b;
        in_ch.reg_c <= c;
        in_ch.imm16 <= i16;
        in_ch.imm24 <= i24;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        if (op == OP_CALL && call_depth < STACK_ENTRIES)
            call_depth++;
        if (op == OP_RET && call_depth > 0)
            call_depth--;
    endtask

    task automatic write_length(input logic [23:0] v);
        in_ch.valid <= 1'b0;
        wait (outstanding == 0);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] pick_reg();
        return ($urandom_range(99) < 80) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
    endfunction

    function automatic logic [15:0] pick_addr();
        return ($urandom_range(99) < 20) ? 16'hFFF8 + 16'($urandom_range(7))
                                         : 16'($urandom_range(63));
    endfunction

    task automatic random_instr();
        logic [7:0]  op;
        logic [7:0]  c;
        logic [15:0] i16;
        logic [23:0] i24;
        int          r;
        r = $urandom_range(99);
        c = pick_reg();
        i16 = 16'($urandom);
        i24 = 24'($urandom);
        if (r < 10)
        begin
            op = OP_LI;
            if ($urandom_range(1))
                i16 = pick_addr();
        end
        else if (r < 16)
            op = OP_LUI;
        else if (r < 22)
        begin
            op = OP_LD;
            i16 = pick_addr();
        end
        else if (r < 28)
        begin
            op = OP_LDP;
            c = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(6));
        end
        else if (r < 34)
        begin
            op = OP_ST;
            i16 = pick_addr();
        end
        else if (r < 40)
        begin
            op = OP_STP;
            c = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(6));
        end
        else if (r < 66)
            op = 8'($urandom_range(OP_MOV, OP_LTES));
        else if (r < 74)
            op = 8'($urandom_range(OP_JMP, OP_JNZ));
        else if (r < 79)
        begin
            op = (call_depth < 250) ? OP_CALL : OP_NOP;
            i24 = 24'($urandom_range(24'h100000, 24'h6FFFFF));
        end
        else if (r < 85)
            op = (call_depth > 1) ? OP_RET : OP_NOP;
        else if (r < 88)
            op = OP_KCALL;
        else
            op = OP_NOP;
        send_instr(op, pick_reg(), pick_reg(), c, i16, i24);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.opcode = '0;
        in_ch.reg_a = '0;
        in_ch.reg_b = '0;
        in_ch.reg_c = '0;
        in_ch.imm16 = '0;
        in_ch.imm24 = '0;
        out_ch.ready = 1'b0;
        call_depth = 0;
        snd_idle = 23;
        rcv_idle = 57;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_length(24'd0);
        write_length(24'hFFFFFF);

        send_instr(OP_LI, 8'd1, 8'd0, 8'd0, 16'hFFFF, 24'd0);
        send_instr(OP_LUI, 8'd1, 8'd0, 8'd0, 16'hFFFF, 24'd0);
        send_instr(OP_LI, 8'd3, 8'd0, 8'd0, 16'd32, 24'd0);
        send_instr(OP_LI, 8'd4, 8'd0, 8'd0, 16'd5, 24'd0);
        send_instr(OP_ADD, 8'd5, 8'd1, 8'd1, 16'd0, 24'd0);
        send_instr(OP_SUB, 8'd6, 8'd2, 8'd1, 16'd0, 24'd0);
        send_instr(OP_MUL, 8'd7, 8'd1, 8'd1, 16'd0, 24'd0);
        send_instr(OP_DIVU, 8'd8, 8'd1, 8'd2, 16'd0, 24'd0);
        send_instr(OP_MODU, 8'd9, 8'd1, 8'd2, 16'd0, 24'd0);
        send_instr(OP_DIVU, 8'd10, 8'd1, 8'd4, 16'd0, 24'd0);
        send_instr(OP_SHL, 8'd11, 8'd1, 8'd3, 16'd0, 24'd0);
        send_instr(OP_SHR, 8'd12, 8'd1, 8'd4, 16'd0, 24'd0);
        send_instr(OP_LTS, 8'd13, 8'd1, 8'd4, 16'd0, 24'd0);
        send_instr(OP_LTEU, 8'd14, 8'd1, 8'd4, 16'd0, 24'd0);
        send_instr(OP_ST, 8'd7, 8'd0, 8'd0, 16'hFFFE, 24'd0);
        send_instr(OP_LD, 8'd15, 8'd0, 8'd0, 16'hFFFE, 24'd0);
        send_instr(OP_LI, 8'd16, 8'd0, 8'd0, 16'hFFFF, 24'd0);
        send_instr(OP_STP, 8'd1, 8'd16, 8'd255, 16'd0, 24'd0);
        send_instr(OP_LDP, 8'd17, 8'd16, 8'd2, 16'd0, 24'd0);
        send_instr(OP_LDP, 8'd18, 8'd16, 8'd0, 16'd0, 24'd0);
        send_instr(OP_JMP, 8'd0, 8'd0, 8'd0, 16'h8000, 24'd0);
        send_instr(OP_JZ, 8'd2, 8'd0, 8'd0, 16'h7FFF, 24'd0);
        send_instr(OP_KCALL, 8'd0, 8'd0, 8'd0, 16'd0, 24'hFFFFFF);
        send_instr(OP_CALL, 8'd0, 8'd0, 8'd0, 16'd0, 24'h400000);

        for (int phase = 0; phase < 3; phase++)
        begin
            snd_idle = (phase == 0) ? 23 : (phase == 1) ? 57 : 0;
            rcv_idle = (phase == 0) ? 57 : (phase == 1) ? 23 : 0;
            if (phase == 1)
                write_length(24'($urandom_range(24'h800000, 24'hFFFFFE)));
            if (phase == 2)
                write_length(24'hFFFFFF);
            for (int n = 0; n < 530; n++)
            begin
                if (phase == 2 && n == 100)
                    -> begin_stall;
                random_instr();
            end
        end

        case ($urandom_range(4))
            0: send_instr(OP_HALT, 8'd0, 8'd0, 8'd0, 16'd0, 24'd0);
            1: send_instr(8'($urandom_range(8'h20, 8'hFF)), 8'd0, 8'd0, 8'd0, 16'd0, 24'd0);
            2:
            begin
                while (call_depth < STACK_ENTRIES)
                    send_instr(OP_CALL, 8'd0, 8'd0, 8'd0, 16'd0, 24'h400000);
                send_instr(OP_CALL, 8'd0, 8'd0, 8'd0, 16'd0, 24'h400000);
            end
            3:
            begin
                while (call_depth > 0)
                    send_instr(OP_RET, 8'd0, 8'd0, 8'd0, 16'd0, 24'd0);
                send_instr(OP_RET, 8'd0, 8'd0, 8'd0, 16'd0, 24'd0);
            end
            default:
            begin
                write_length(24'd1);
                send_instr(OP_NOP, 8'd0, 8'd0, 8'd0, 16'd0, 24'd0);
            end
        endcase
        for (int n = 0; n < 20; n++)
            send_instr(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                       16'($urandom), 24'($urandom));

        in_ch.valid <= 1'b0;
        wait (outstanding == 0);
        repeat (100) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
